FILE: rtl/nsd_pkg.sv
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared constants, codes and helpers of the nearest seed distance block.
// ----------------------------------------------------------------------------
package nsd_pkg;

    // Default sizing
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 12;

    // Fixed field widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int COUNT_W    = 7;
    localparam int GRID_W     = 13;
    localparam int FRAC_BITS  = 4;
    localparam int OUT_W      = 18;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd2;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Address bits for a table of n entries, at least one
    function automatic int addr_bits(input int n);
        int w;
        w = (n > 1) ? $clog2(n) : 1;
        return w;
    endfunction

endpackage

FILE: rtl/nearest_seed_distance.sv
// ----------------------------------------------------------------------------
// nearest_seed_distance
// Cellular (F1, Euclidean) noise: distance from a query to the nearest seed.
// ----------------------------------------------------------------------------
// A load transfer (mode 0) writes one seed point into the seed memory and
// produces no result. A query transfer (mode 1) scans the first point_count
// seeds (capped at MAX_POINTS), one per cycle through the memory read port,
// keeping the smallest squared distance; the bit-serial square root unit
// then takes the root of that minimum scaled by 256. While a query is in
// progress o_in_ready is low; with point_count 0 it skips the scan and the
// root and returns the bound. The result is the distance times 16,
// truncated, and never above 16 * (grid_height + grid_width). It waits in an
// output register, so a new item is taken while it is pending. Configuration
// is written through its own channel, always ready; the user must write it
// only while the block is idle, as the block does not enforce this. Seeds
// read by a query must have been loaded first.
// ----------------------------------------------------------------------------
module nearest_seed_distance #(
    parameter int MAX_POINTS = nsd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nsd_pkg::COORD_BITS_DEF,
    localparam int IDX_W     = nsd_pkg::addr_bits(MAX_POINTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nsd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [IDX_W-1:0]              i_point_index,
    input  logic [COORD_BITS-1:0]         i_coord_y,
    input  logic [COORD_BITS-1:0]         i_coord_x,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nsd_pkg::OUT_W-1:0]     o_nearest_distance
);
    import nsd_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int D2_W  = SQ_W + 1;
    localparam int RW    = COORD_BITS + 5;
    localparam int OPW   = 2 * RW;
    localparam int CW    = (RW > OUT_W) ? RW : OUT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_ROOT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [COUNT_W-1:0] r_point_count;
    logic [GRID_W-1:0]  r_grid_h;
    logic [GRID_W-1:0]  r_grid_w;

    // query context and scan pipeline
    logic [COORD_BITS-1:0] r_qy, r_qx;
    logic [CNT_W-1:0]      r_used, n_used;
    logic [CNT_W-1:0]      r_rd_addr;
    logic                  r_rd_vld;
    logic                  r_sq_vld;
    logic [SQ_W-1:0]       r_sq_y, r_sq_x;
    logic [D2_W-1:0]       r_min2;
    logic                  r_first;
    logic [OUT_W-1:0]      r_res;

    // output register
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic                  in_xfer;
    logic                  wr_en;
    logic                  rd_en;
    logic                  issue_done;
    logic [2*COORD_BITS-1:0] rd_data;
    logic [COORD_BITS-1:0] seed_y, seed_x;
    logic [COORD_BITS-1:0] dy, dx;
    logic [D2_W-1:0]       d2;
    logic [OUT_W-1:0]      bound;
    logic                  sqrt_start;
    logic                  sqrt_done;
    logic [RW-1:0]         sqrt_root;
    logic [OPW-1:0]        sqrt_operand;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;

    // Drop loads aimed past the end of the table
    assign wr_en = in_xfer && (i_mode == MODE_LOAD) && (32'(i_point_index) < MAX_POINTS);

    assign issue_done = (r_rd_addr == r_used);
    assign rd_en      = (r_state == S_SCAN) && !issue_done;

    // Cap the seed count at the table size
    assign n_used = (32'(r_point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                      : CNT_W'(r_point_count);

    // Starting bound: (height + width) in fixed point with four fraction bits
    assign bound = {(14'(r_grid_h) + 14'(r_grid_w)), {FRAC_BITS{1'b0}}};

    nsd_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_POINTS)
    ) u_seed_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_point_index),
        .i_wr_data ({i_coord_y, i_coord_x}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Distance terms of the seed just read
    always_comb begin
        seed_y = rd_data[2*COORD_BITS-1:COORD_BITS];
        seed_x = rd_data[COORD_BITS-1:0];
        dy     = (r_qy > seed_y) ? (r_qy - seed_y) : (seed_y - r_qy);
        dx     = (r_qx > seed_x) ? (r_qx - seed_x) : (seed_x - r_qx);
        d2     = D2_W'(r_sq_y) + D2_W'(r_sq_x);
    end

    // Scale the minimum by 256 so the root carries four fraction bits
    assign sqrt_operand = OPW'({r_min2, {(2 * FRAC_BITS){1'b0}}});

    nsd_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sqrt_start),
        .i_operand (sqrt_operand),
        .o_done    (sqrt_done),
        .o_root    (sqrt_root)
    );

    // Sequencer
    always_comb begin
        n_state    = r_state;
        sqrt_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_mode == MODE_QUERY)) begin
                    n_state = (n_used == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // leave once every seed is issued and the pipeline drained
                if (issue_done && !r_rd_vld && !r_sq_vld) begin
                    n_state    = S_ROOT;
                    sqrt_start = 1'b1;
                end
            end
            S_ROOT: begin
                if (sqrt_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= '0;
            r_grid_h      <= GRID_W'(256);
            r_grid_w      <= GRID_W'(256);
            r_rd_vld      <= 1'b0;
            r_sq_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_POINT_COUNT: r_point_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_GRID_HEIGHT: r_grid_h      <= i_cfg_data[GRID_W-1:0];
                    CFG_GRID_WIDTH:  r_grid_w      <= i_cfg_data[GRID_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Latch the query and preset the result to the bound
            if (in_xfer && (i_mode == MODE_QUERY)) begin
                r_qy      <= i_coord_y;
                r_qx      <= i_coord_x;
                r_used    <= n_used;
                r_rd_addr <= '0;
                r_first   <= 1'b1;
                r_res     <= bound;
            end

            // Advance the scan: read, square, compare
            if (rd_en) begin
                r_rd_addr <= r_rd_addr + CNT_W'(1);
            end
            r_rd_vld <= rd_en;
            r_sq_vld <= r_rd_vld;
            if (r_rd_vld) begin
                r_sq_y <= SQ_W'(dy) * SQ_W'(dy);
                r_sq_x <= SQ_W'(dx) * SQ_W'(dx);
            end
            if (r_sq_vld && (r_first || (d2 < r_min2))) begin
                r_min2  <= d2;
                r_first <= 1'b0;
            end

            // Keep the root only where it beats the bound
            if ((r_state == S_ROOT) && sqrt_done) begin
                if (CW'(sqrt_root) < CW'(r_res)) begin
                    r_res <= OUT_W'(sqrt_root);
                end
            end

            if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_res;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_nearest_distance = r_out_data;

endmodule

FILE: rtl/nsd_ram.sv
// ----------------------------------------------------------------------------
// nsd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = nsd_pkg::MAX_POINTS_DEF,
    localparam int AW   = nsd_pkg::addr_bits(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    import nsd_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/nsd_sqrt.sv
// ----------------------------------------------------------------------------
// nsd_sqrt
// Restoring integer square root, one result bit per cycle (floor of root).
// ----------------------------------------------------------------------------
module nsd_sqrt #(
    parameter int RW   = 17,
    localparam int OPW = 2 * RW,
    localparam int SW  = $clog2(RW + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [OPW-1:0] i_operand,
    output logic           o_done,
    output logic [RW-1:0]  o_root
);
    logic           r_busy;
    logic           r_done;
    logic [SW-1:0]  r_cnt;
    logic [OPW-1:0] r_op;
    logic [RW+1:0]  r_rem;
    logic [RW-1:0]  r_root;

    logic [RW+3:0]  rem_sh;
    logic [RW+3:0]  trial;
    logic [RW+3:0]  diff;
    logic           fits;

    // Bring down the next two operand bits and try the next root bit
    always_comb begin
        rem_sh = {r_rem, r_op[OPW-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(RW);
                r_op   <= i_operand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_op   <= r_op << 2;
                r_rem  <= fits ? diff[RW+1:0] : rem_sh[RW+1:0];
                r_root <= {r_root[RW-2:0], fits};
                r_cnt  <= r_cnt - SW'(1);
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: bench/tb_nearest_seed_distance.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_seed_distance
// Self-checking bench for the nearest seed distance block. It loads seeds,
// tries extreme register settings, then random ones, and checks every query
// result against a typed value or a local distance predictor. Both handshakes
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_nearest_seed_distance;
    import nsd_pkg::*;

    localparam int SEEDS     = MAX_POINTS_DEF;
    localparam int SLOT_W    = $clog2(SEEDS);
    localparam int COORD_W   = COORD_BITS_DEF;
    localparam int COORD_MAX = (1 << COORD_W) - 1;

    // Index past the end of the register list; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int IDLE_PCT        = 18;
    localparam int SETTLE_CYCLES   = 100;   // longer than the slowest query
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int LOAD_PCT        = 30;
    localparam int QUIET_PHASE     = 4;
    localparam int HOLD_PHASE      = 1;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int MAX_REPORTS     = 40;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  i_mode        = MODE_LOAD;
    logic [SLOT_W-1:0]     i_point_index = '0;
    logic [COORD_W-1:0]    i_coord_y     = '0;
    logic [COORD_W-1:0]    i_coord_x     = '0;
    logic                  i_out_ready   = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [OUT_W-1:0]      o_nearest_distance;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    nearest_seed_distance i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_point_index     (i_point_index),
        .i_coord_y         (i_coord_y),
        .i_coord_x         (i_coord_x),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_nearest_distance(o_nearest_distance)
    );

    // ------------------------------------------------------------------------
    // Local copy of the block's state and registers, at reset values
    // ------------------------------------------------------------------------
    logic [COORD_W-1:0] seed_y [SEEDS];
    logic [COORD_W-1:0] seed_x [SEEDS];
    bit                 seed_loaded [SEEDS];
    logic [COUNT_W-1:0] cfg_count  = '0;
    logic [GRID_W-1:0]  cfg_height = GRID_W'(256);
    logic [GRID_W-1:0]  cfg_width  = GRID_W'(256);

    logic [OUT_W-1:0] pending_distances [$];
    int               mismatches   = 0;
    bit               quiet        = 1'b0;  // no idling on either side
    bit               hold_request = 1'b0;  // ask the result side to hold off

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Slots scanned by a query: the count register, capped at the table size
    function automatic int seeds_in_use();
        return (int'(cfg_count) > SEEDS) ? SEEDS : int'(cfg_count);
    endfunction

    // Nearest distance times 16, truncated, bounded by 16 * (height + width)
    function automatic logic [OUT_W-1:0] predict_distance(
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] x
    );
        longint unsigned dy, dx, d2, best_d2, scaled, bound, root, trial;
        bit found;
        found   = 1'b0;
        best_d2 = 0;
        for (int i = 0; i < seeds_in_use(); i++) begin
            dy = (y > seed_y[i]) ? y - seed_y[i] : seed_y[i] - y;
            dx = (x > seed_x[i]) ? x - seed_x[i] : seed_x[i] - x;
            d2 = dy * dy + dx * dx;
            if (!found || d2 < best_d2) begin
                best_d2 = d2;
                found   = 1'b1;
            end
        end
        bound = (longint'(cfg_height) + longint'(cfg_width)) << FRAC_BITS;
        if (found) begin
            // Largest root whose square fits, one bit at a time from the top
            scaled = best_d2 << (2 * FRAC_BITS);
            root   = 0;
            for (int b = 17; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= scaled)
                    root = trial;
            end
            if (root < bound)
                bound = root;
        end
        return bound[OUT_W-1:0];
    endfunction

    // Coordinate near a center, with the edges of the grid now and then
    function automatic logic [COORD_W-1:0] pick_coord(input int center, input int spread);
        int v;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: begin
                v = center + int'($urandom_range(0, 2 * spread)) - spread;
                if (v < 0)
                    v = 0;
                if (v > COORD_MAX)
                    v = COORD_MAX;
                return v[COORD_W-1:0];
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Each task starts and ends right after a rising edge; valid is
    // left high after a transfer so a following item keeps it high.
    // ------------------------------------------------------------------------
    task automatic send_item(
        input logic               mode,
        input logic [SLOT_W-1:0]  slot,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] x,
        input bit                 use_given,
        input logic [OUT_W-1:0]   given
    );
        logic [OUT_W-1:0] want;
        while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_point_index <= slot;
        i_coord_y     <= y;
        i_coord_x     <= x;
        do @(posedge i_clk); while (!o_in_ready);
        // Transfer taken at this edge: advance the local state
        if (mode == MODE_LOAD) begin
            seed_y[slot]      = y;
            seed_x[slot]      = x;
            seed_loaded[slot] = 1'b1;
        end else begin
            want = predict_distance(y, x);
            pending_distances.push_back(use_given ? given : want);
        end
    endtask

    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  index,
        input logic [CFG_DATA_W-1:0] data
    );
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_POINT_COUNT: cfg_count  = data[COUNT_W-1:0];
            CFG_GRID_HEIGHT: cfg_height = data[GRID_W-1:0];
            CFG_GRID_WIDTH:  cfg_width  = data[GRID_W-1:0];
            default: ;
        endcase
    endtask

    // Drop valid, drain every expected distance, then let a load finish too
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed table: typed results only where they follow at a glance
    // ------------------------------------------------------------------------
    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  mode;
        logic [SLOT_W-1:0]     slot;
        logic [COORD_W-1:0]    y;
        logic [COORD_W-1:0]    x;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  given;
        logic [OUT_W-1:0]      distance;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 25;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        // no seeds in use: bound of 16 * (256 + 256)
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd0,    12'd0,    CFG_POINT_COUNT, 13'd0, 1'b1, 18'd8192},
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd4095, 12'd4095, CFG_POINT_COUNT, 13'd0, 1'b1, 18'd8192},
        '{ROW_ITEM, MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_POINT_COUNT, 13'd0, 1'b0, 18'd0},
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_POINT_COUNT, 13'd1, 1'b0, 18'd0},
        // one seed at the origin: exact hit and a 3-4-5 triangle
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd0,    12'd0,    CFG_POINT_COUNT, 13'd0, 1'b1, 18'd0},
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd3,    12'd4,    CFG_POINT_COUNT, 13'd0, 1'b1, 18'd80},
        // far corner: clipped by the grid bound
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd4095, 12'd4095, CFG_POINT_COUNT, 13'd0, 1'b1, 18'd8192},
        '{ROW_ITEM, MODE_LOAD,  6'd63, 12'd4095, 12'd4095, CFG_POINT_COUNT, 13'd0, 1'b0, 18'd0},
        '{ROW_ITEM, MODE_LOAD,  6'd1,  12'd100,  12'd100,  CFG_POINT_COUNT, 13'd0, 1'b0, 18'd0},
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_POINT_COUNT, 13'd2, 1'b0, 18'd0},
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_GRID_HEIGHT, 13'd4096, 1'b0, 18'd0},
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_GRID_WIDTH,  13'd4096, 1'b0, 18'd0},
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd4095, 12'd4095, CFG_POINT_COUNT, 13'd0, 1'b0, 18'd0},
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd100,  12'd103,  CFG_POINT_COUNT, 13'd0, 1'b1, 18'd48},
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd2048, 12'd1024, CFG_POINT_COUNT, 13'd0, 1'b0, 18'd0},
        // zero grid size: the bound itself is zero
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_GRID_HEIGHT, 13'd0, 1'b0, 18'd0},
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_GRID_WIDTH,  13'd0, 1'b0, 18'd0},
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd3,    12'd4,    CFG_POINT_COUNT, 13'd0, 1'b1, 18'd0},
        // write past the register list: nothing may change
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_UNUSED, 13'h1FFF, 1'b0, 18'd0},
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd100,  12'd100,  CFG_POINT_COUNT, 13'd0, 1'b1, 18'd0},
        // widest grid registers
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_GRID_HEIGHT, 13'h1FFF, 1'b0, 18'd0},
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_GRID_WIDTH,  13'h1FFF, 1'b0, 18'd0},
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd4095, 12'd0,    CFG_POINT_COUNT, 13'd0, 1'b0, 18'd0},
        '{ROW_CFG,  MODE_LOAD,  6'd0,  12'd0,    12'd0,    CFG_POINT_COUNT, 13'd0, 1'b0, 18'd0},
        '{ROW_ITEM, MODE_QUERY, 6'd0,  12'd1234, 12'd2345, CFG_POINT_COUNT, 13'd0, 1'b1, 18'd262112}
    };

    // ------------------------------------------------------------------------
    // Result side: random stalls, a quiet stretch, and one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_ready
        int hold_left;
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (quiet) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each result transfer with the oldest expected distance
    always @(posedge i_clk) begin : result_check
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_distances.size() == 0) begin
                flag_mismatch($sformatf("distance %0d with nothing expected",
                                        o_nearest_distance));
            end else begin
                want = pending_distances.pop_front();
                if (o_nearest_distance !== want)
                    flag_mismatch($sformatf("nearest_distance %0d, expected %0d",
                                            o_nearest_distance, want));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_directed_row         r;
        bit                    cfg_active;
        logic [CFG_DATA_W-1:0] count_data, height_data, width_data;
        int                    center_y, center_x, spread, guard;

        foreach (seed_loaded[i]) begin
            seed_y[i]      = '0;
            seed_x[i]      = '0;
            seed_loaded[i] = 1'b0;
        end

        // Hold reset at the start, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; register writes wait for an idle block
        cfg_active = 1'b0;
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            r = directed_rows[n];
            if (r.kind == ROW_CFG) begin
                if (!cfg_active)
                    settle_block();
                write_register(r.reg_index, r.reg_data);
                cfg_active = 1'b1;
            end else begin
                if (cfg_active) begin
                    i_cfg_valid <= 1'b0;
                    cfg_active  = 1'b0;
                end
                send_item(r.mode, r.slot, r.y, r.x, r.given, r.distance);
            end
        end

        // Random phases: extremes first, then random settings
        for (int phase = 0; phase < PHASES; phase++) begin
            settle_block();
            case (phase)
                0: begin    // count above capacity, widest grid
                    count_data  = '1;
                    height_data = '1;
                    width_data  = '1;
                end
                1: begin    // full table, largest grid in range
                    count_data  = CFG_DATA_W'(SEEDS);
                    height_data = CFG_DATA_W'(4096);
                    width_data  = CFG_DATA_W'(4096);
                end
                2: begin    // one seed, smallest grid
                    count_data  = CFG_DATA_W'(1);
                    height_data = CFG_DATA_W'(1);
                    width_data  = CFG_DATA_W'(1);
                end
                3: begin    // no seeds, zero height
                    count_data  = '0;
                    height_data = '0;
                    width_data  = CFG_DATA_W'($urandom_range(1, 4096));
                end
                default: begin
                    count_data = ($urandom_range(1) == 0)
                               ? CFG_DATA_W'($urandom_range(0, 127))
                               : CFG_DATA_W'($urandom_range(0, 8191));
                    case ($urandom_range(3))
                        0:       height_data = CFG_DATA_W'($urandom_range(0, 8191));
                        1:       height_data = CFG_DATA_W'($urandom_range(1, 64));
                        default: height_data = CFG_DATA_W'($urandom_range(1, 4096));
                    endcase
                    case ($urandom_range(3))
                        0:       width_data = CFG_DATA_W'($urandom_range(0, 8191));
                        1:       width_data = CFG_DATA_W'($urandom_range(1, 64));
                        default: width_data = CFG_DATA_W'($urandom_range(1, 4096));
                    endcase
                end
            endcase
            write_register(CFG_POINT_COUNT, count_data);
            write_register(CFG_GRID_HEIGHT, height_data);
            write_register(CFG_GRID_WIDTH, width_data);
            write_register(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));
            i_cfg_valid <= 1'b0;

            quiet = (phase == QUIET_PHASE);

            // Cluster seeds and queries so nearest distances mostly stay under the bound
            center_y = $urandom_range(0, COORD_MAX);
            center_x = $urandom_range(0, COORD_MAX);
            case ($urandom_range(2))
                0:       spread = COORD_MAX;
                1:       spread = 255;
                default: spread = 15;
            endcase

            // Load every slot the query scan will read that is still empty
            for (int s = 0; s < seeds_in_use(); s++)
                if (!seed_loaded[s])
                    send_item(MODE_LOAD, SLOT_W'(s), pick_coord(center_y, spread),
                              pick_coord(center_x, spread), 1'b0, '0);

            // Stall the result side for a long stretch while queries keep coming
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;

            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < LOAD_PCT)
                    send_item(MODE_LOAD, SLOT_W'($urandom_range(0, SEEDS - 1)),
                              pick_coord(center_y, spread), pick_coord(center_x, spread),
                              1'b0, '0);
                else
                    send_item(MODE_QUERY, SLOT_W'($urandom_range(0, SEEDS - 1)),
                              pick_coord(center_y, spread), pick_coord(center_x, spread),
                              1'b0, '0);
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        // Drain the outstanding results, then watch for strays
        guard = 0;
        while (pending_distances.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_distances.size() != 0)
            flag_mismatch($sformatf("%0d expected distances never arrived",
                                    pending_distances.size()));

        if (mismatches == 0) begin
            $display("PASS nearest_seed_distance");
        end else begin
            $display("FAIL nearest_seed_distance");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #4000000;
        $display("FAIL nearest_seed_distance");
        $finish;
    end

endmodule
